// ===== rtl/odfw_pkg.sv =====
// odfw_pkg: shared constants and types for the ordered depth-first walk unit
`timescale 1ns / 1ps

package odfw_pkg;

  // node numbers on the stream fields
  localparam int NODE_W   = 7;
  // stream data widths, whole bytes
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 8;

  // command codes carried in tuser
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_START = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_BR,
    ST_ADD_B,
    ST_CAND,
    ST_SEL,
    ST_POP
  } state_t;

endpackage

// ===== rtl/ordered_depth_first_walk_unit.sv =====
// ordered_depth_first_walk_unit: edge loader and depth-first walk sequencer
`timescale 1ns / 1ps

// Undirected edges are loaded one request at a time into a neighbor-mask
// memory (one row of MAX_NODES bits per node); a start request walks the
// graph depth first from node 1, always taking the lowest-numbered unvisited
// neighbor, and sends each visited node on the master stream, with tlast on
// the final one. An add request is a read-modify-write of two rows through
// the single read port of the mask memory: row a is read on accept and
// written in ST_ADD_A, row b is read in ST_ADD_BR and written in ST_ADD_B.
// Each forward step of a walk passes ST_CAND and ST_SEL, each backtrack
// ST_SEL, ST_POP and ST_CAND, as the mask read is registered; output back
// pressure holds the walk in ST_SEL.
// Rows carry valid bits cleared by reset, so no clearing pass is needed and
// the block takes requests right after reset. New requests are taken only
// while the sequencer is idle; a finished result may still wait in the
// output register at that time.
module ordered_depth_first_walk_unit #(
  parameter int MAX_NODES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // node_count register
  input  logic                          cfg_we,
  input  logic [odfw_pkg::NODE_W-1:0]   cfg_data,
  // request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [odfw_pkg::S_DATA_W-1:0] s_tdata,  // node_a [6:0], node_b [13:7], zero pad
  input  logic                          s_tuser,  // cmd [0]
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [odfw_pkg::M_DATA_W-1:0] m_tdata,  // visited_node [6:0], zero pad
  output logic                          m_tlast
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int DEP_W = $clog2(MAX_NODES + 1);
  localparam int CW    = (IDX_W + 1 > odfw_pkg::NODE_W) ? IDX_W + 1 : odfw_pkg::NODE_W;

  odfw_pkg::state_t state, state_next;

  logic [odfw_pkg::NODE_W-1:0] node_count;

  // mask memory ports
  logic                 mrd_en;
  logic [IDX_W-1:0]     mrd_addr;
  logic [MAX_NODES-1:0] mrd_data;
  logic [IDX_W-1:0]     mrd_addr_q;
  logic                 mwr_en;
  logic [IDX_W-1:0]     mwr_addr;
  logic [MAX_NODES-1:0] mwr_data;
  logic [MAX_NODES-1:0] row_valid;

  // stack memory ports
  logic                 srd_en;
  logic [IDX_W-1:0]     srd_addr;
  logic [IDX_W-1:0]     srd_data;
  logic                 swr_en;
  logic [IDX_W-1:0]     swr_addr;
  logic [IDX_W-1:0]     swr_data;

  // walk registers
  logic [IDX_W-1:0]     ia;
  logic [IDX_W-1:0]     ib;
  logic [DEP_W-1:0]     depth;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] lim_mask;
  logic [MAX_NODES-1:0] iso;
  logic [IDX_W-1:0]     pend;

  // combinational helpers
  logic [CW-1:0]        count_c;
  logic [CW-1:0]        limit_c;
  logic [MAX_NODES-1:0] lim_mask_c;
  logic [CW-1:0]        a_cw;
  logic [CW-1:0]        b_cw;
  logic [IDX_W-1:0]     a_idx;
  logic [IDX_W-1:0]     b_idx;
  logic                 in_range;
  logic [MAX_NODES-1:0] row_c;
  logic [MAX_NODES-1:0] cand_c;
  logic [IDX_W-1:0]     nx;
  logic                 out_free;
  logic                 emit;
  logic                 emit_last;
  logic [CW-1:0]        emit_val;

  // node count clamp and active-node mask
  always_comb begin
    count_c = (node_count == '0) ? CW'(1) : CW'(node_count);
    limit_c = (count_c > CW'(MAX_NODES)) ? CW'(MAX_NODES) : count_c;
    for (int i = 0; i < MAX_NODES; i++) begin
      lim_mask_c[i] = (CW'(i) < limit_c);
    end
  end

  // endpoint decode and range check
  always_comb begin
    a_cw     = CW'(s_tdata[odfw_pkg::NODE_W-1:0]);
    b_cw     = CW'(s_tdata[2*odfw_pkg::NODE_W-1:odfw_pkg::NODE_W]);
    a_idx    = IDX_W'(a_cw - CW'(1));
    b_idx    = IDX_W'(b_cw - CW'(1));
    in_range = (a_cw != '0) && (a_cw <= limit_c) && (b_cw != '0) && (b_cw <= limit_c);
  end

  // row read data, empty when the row was never written
  assign row_c  = row_valid[mrd_addr_q] ? mrd_data : '0;
  assign cand_c = row_c & ~visited & lim_mask;

  // one-hot lowest candidate to index
  always_comb begin
    nx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (iso[i]) begin
        nx = nx | IDX_W'(i);
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign emit_val = CW'(pend) + CW'(1);

  // next state and memory controls
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mrd_en     = 1'b0;
    mrd_addr   = '0;
    mwr_en     = 1'b0;
    mwr_addr   = '0;
    mwr_data   = '0;
    srd_en     = 1'b0;
    srd_addr   = '0;
    swr_en     = 1'b0;
    swr_addr   = '0;
    swr_data   = '0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    unique case (state)
      odfw_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == odfw_pkg::CMD_START) begin
            mrd_en     = 1'b1;
            mrd_addr   = '0;
            swr_en     = 1'b1;
            swr_addr   = '0;
            swr_data   = '0;
            state_next = odfw_pkg::ST_CAND;
          end else if (in_range) begin
            mrd_en     = 1'b1;
            mrd_addr   = a_idx;
            state_next = odfw_pkg::ST_ADD_A;
          end
        end
      end
      odfw_pkg::ST_ADD_A: begin
        mwr_en     = 1'b1;
        mwr_addr   = ia;
        mwr_data   = row_c | (MAX_NODES'(1) << ib);
        state_next = odfw_pkg::ST_ADD_BR;
      end
      odfw_pkg::ST_ADD_BR: begin
        mrd_en     = 1'b1;
        mrd_addr   = ib;
        state_next = odfw_pkg::ST_ADD_B;
      end
      odfw_pkg::ST_ADD_B: begin
        mwr_en     = 1'b1;
        mwr_addr   = ib;
        mwr_data   = row_c | (MAX_NODES'(1) << ia);
        state_next = odfw_pkg::ST_IDLE;
      end
      odfw_pkg::ST_CAND: begin
        state_next = odfw_pkg::ST_SEL;
      end
      odfw_pkg::ST_SEL: begin
        if (iso != '0) begin
          // push: wait until the previous node can leave
          if (out_free) begin
            emit       = 1'b1;
            swr_en     = 1'b1;
            swr_addr   = depth[IDX_W-1:0];
            swr_data   = nx;
            mrd_en     = 1'b1;
            mrd_addr   = nx;
            state_next = odfw_pkg::ST_CAND;
          end
        end else if (depth == DEP_W'(1)) begin
          // walk done: last node leaves with tlast
          if (out_free) begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            state_next = odfw_pkg::ST_IDLE;
          end
        end else begin
          srd_en     = 1'b1;
          srd_addr   = IDX_W'(depth - DEP_W'(2));
          state_next = odfw_pkg::ST_POP;
        end
      end
      odfw_pkg::ST_POP: begin
        mrd_en     = 1'b1;
        mrd_addr   = srd_data;
        state_next = odfw_pkg::ST_CAND;
      end
      default: begin
        state_next = odfw_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= odfw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= odfw_pkg::NODE_W'(64);
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  // row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (mwr_en) begin
      row_valid[mwr_addr] <= 1'b1;
    end
  end

  // stack depth
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (state == odfw_pkg::ST_IDLE && s_tvalid && s_tuser == odfw_pkg::CMD_START) begin
      depth <= DEP_W'(1);
    end else if (state == odfw_pkg::ST_SEL) begin
      if (iso != '0) begin
        if (out_free) begin
          depth <= depth + DEP_W'(1);
        end
      end else if (depth != DEP_W'(1) || out_free) begin
        depth <= depth - DEP_W'(1);
      end
    end
  end

  // walk payload registers
  always_ff @(posedge clk) begin
    if (mrd_en) begin
      mrd_addr_q <= mrd_addr;
    end
    unique case (state)
      odfw_pkg::ST_IDLE: begin
        ia <= a_idx;
        ib <= b_idx;
        if (s_tvalid && s_tuser == odfw_pkg::CMD_START) begin
          visited  <= MAX_NODES'(1);
          pend     <= '0;
          lim_mask <= lim_mask_c;
        end
      end
      odfw_pkg::ST_CAND: begin
        iso <= cand_c & (~cand_c + MAX_NODES'(1));
      end
      odfw_pkg::ST_SEL: begin
        if (iso != '0 && out_free) begin
          visited <= visited | iso;
          pend    <= nx;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= odfw_pkg::M_DATA_W'(odfw_pkg::NODE_W'(emit_val));
      m_tlast <= emit_last;
    end
  end

  // neighbor masks, one row per node
  odfw_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_mask_ram (
    .clk   (clk),
    .we    (mwr_en),
    .waddr (mwr_addr),
    .wdata (mwr_data),
    .re    (mrd_en),
    .raddr (mrd_addr),
    .rdata (mrd_data)
  );

  // path stack
  odfw_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_NODES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (swr_en),
    .waddr (swr_addr),
    .wdata (swr_data),
    .re    (srd_en),
    .raddr (srd_addr),
    .rdata (srd_data)
  );

endmodule

// ===== rtl/odfw_ram.sv =====
// odfw_ram: simple dual-port ram, one write port and one registered read port
`timescale 1ns / 1ps

module odfw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sim/ordered_depth_first_walk_unit_test.sv =====
// ordered_depth_first_walk_unit_test: self-checking testbench for the depth-first walk unit
`timescale 1ns / 1ps

module ordered_depth_first_walk_unit_test;

  localparam int NODES        = 64;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 5000;

  // receiver stall modes
  localparam int READY_ALWAYS  = 0;
  localparam int READY_RANDOM  = 1;
  localparam int READY_PATTERN = 2;

  typedef struct packed {
    logic [odfw_pkg::NODE_W-1:0] node;
    logic                        last;
  } visit_t;

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          cfg_we   = 1'b0;
  logic [odfw_pkg::NODE_W-1:0]   cfg_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [odfw_pkg::S_DATA_W-1:0] s_tdata  = '0;  // node_a [6:0], node_b [13:7], zero pad
  logic                          s_tuser  = 1'b0;  // cmd [0]
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [odfw_pkg::M_DATA_W-1:0] m_tdata;  // visited_node [6:0], zero pad
  logic                          m_tlast;

  // shadow graph and node count
  logic [NODES-1:0]            adj_rows [NODES];
  logic [odfw_pkg::NODE_W-1:0] node_count_shadow = 7'd64;
  // visit order still owed by the block
  visit_t                      visit_q[$];

  int         errors        = 0;
  int         burst_left    = 0;
  bit         gaps_on       = 1'b1;
  int         ready_mode    = READY_ALWAYS;
  logic [7:0] ready_pattern = 8'b1011_0110;
  int         idle_cycles   = 0;

  ordered_depth_first_walk_unit #(
    .MAX_NODES(NODES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // node count as the walk sees it: 0 acts as 1, above the maximum clips
  function automatic int active_nodes();
    if (node_count_shadow == 0) return 1;
    if (node_count_shadow > NODES) return NODES;
    return int'(node_count_shadow);
  endfunction

  // depth-first order from node 1, lowest unvisited neighbor first
  function automatic void walk_from_root();
    logic [NODES-1:0] seen;
    logic [NODES-1:0] cand;
    logic [NODES-1:0] in_use;
    int               path[$];
    visit_t           order[$];
    int               lim;
    int               top;
    int               nx;
    lim    = active_nodes();
    in_use = (lim == NODES) ? '1 : ((64'd1 << lim) - 64'd1);
    seen   = 64'd1;
    path.push_back(0);
    order.push_back('{node: odfw_pkg::NODE_W'(1), last: 1'b0});
    while (path.size() > 0) begin
      top  = path[path.size() - 1];
      cand = adj_rows[top] & ~seen & in_use;
      if (cand == '0 || path.size() >= NODES || order.size() >= NODES) begin
        void'(path.pop_back());
      end else begin
        nx = 0;
        while (!cand[nx]) nx++;
        seen[nx] = 1'b1;
        path.push_back(nx);
        order.push_back('{node: odfw_pkg::NODE_W'(nx + 1), last: 1'b0});
      end
    end
    order[order.size() - 1].last = 1'b1;
    foreach (order[i]) visit_q.push_back(order[i]);
  endfunction

  // apply one accepted request to the shadow state
  function automatic void record_request(logic cmd, logic [odfw_pkg::NODE_W-1:0] a,
                                         logic [odfw_pkg::NODE_W-1:0] b);
    int lim;
    lim = active_nodes();
    if (cmd == odfw_pkg::CMD_START) begin
      walk_from_root();
    end else if (a >= 1 && a <= lim && b >= 1 && b <= lim) begin
      adj_rows[a - 1][b - 1] = 1'b1;
      adj_rows[b - 1][a - 1] = 1'b1;
    end
  endfunction

  // send one request, in bursts with random gaps between them when gaps_on is set
  task automatic send_request(logic cmd, logic [odfw_pkg::NODE_W-1:0] a,
                              logic [odfw_pkg::NODE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, b, a};
    do @(posedge clk); while (!s_tready);
    record_request(cmd, a, b);
  endtask

  // wait until every owed result is in and the block has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (visit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(logic [odfw_pkg::NODE_W-1:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we            <= 1'b0;
    node_count_shadow = value;
  endtask

  // empty graph, duplicates, self loop, out-of-range endpoints at full size
  task automatic test_directed_edges();
    ready_mode = READY_PATTERN;
    gaps_on    = 1'b1;
    send_request(odfw_pkg::CMD_START, 7'd0, 7'd0);
    send_request(odfw_pkg::CMD_ADD, 7'd1, 7'd64);
    send_request(odfw_pkg::CMD_ADD, 7'd64, 7'd2);
    send_request(odfw_pkg::CMD_ADD, 7'd2, 7'd64);
    send_request(odfw_pkg::CMD_ADD, 7'd3, 7'd3);
    send_request(odfw_pkg::CMD_ADD, 7'd0, 7'd5);
    send_request(odfw_pkg::CMD_ADD, 7'd5, 7'd127);
    send_request(odfw_pkg::CMD_ADD, 7'd65, 7'd1);
    send_request(odfw_pkg::CMD_ADD, 7'd64, 7'd63);
    send_request(odfw_pkg::CMD_ADD, 7'd3, 7'd2);
    send_request(odfw_pkg::CMD_START, 7'd127, 7'd127);
  endtask

  // node count at zero, one, shrunk and above the maximum
  task automatic test_node_count_limits();
    ready_mode = READY_RANDOM;
    write_node_count(7'd0);
    send_request(odfw_pkg::CMD_ADD, 7'd1, 7'd2);
    send_request(odfw_pkg::CMD_START, 7'd85, 7'd42);
    write_node_count(7'd127);
    send_request(odfw_pkg::CMD_START, 7'd42, 7'd85);
    write_node_count(7'd3);
    send_request(odfw_pkg::CMD_START, 7'd0, 7'd0);
    send_request(odfw_pkg::CMD_ADD, 7'd1, 7'd3);
    send_request(odfw_pkg::CMD_START, 7'd1, 7'd1);
    write_node_count(7'd1);
    send_request(odfw_pkg::CMD_START, 7'd64, 7'd64);
  endtask

  // random phase: many short chain edges so walks go deep, random in-range edges, some noise
  task automatic test_random_phase(logic [odfw_pkg::NODE_W-1:0] count, int items, int rmode,
                                   bit gaps);
    int lim;
    int pick;
    int a;
    int b;
    write_node_count(count);
    ready_mode = rmode;
    gaps_on    = gaps;
    lim        = active_nodes();
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (i == items - 1 || pick < 9) begin
        send_request(odfw_pkg::CMD_START, odfw_pkg::NODE_W'($urandom_range(0, 127)),
                     odfw_pkg::NODE_W'($urandom_range(0, 127)));
      end else if (pick < 16) begin
        send_request(odfw_pkg::CMD_ADD, odfw_pkg::NODE_W'($urandom_range(0, 127)),
                     odfw_pkg::NODE_W'($urandom_range(0, 127)));
      end else if (pick < 60) begin
        a = $urandom_range(1, lim);
        b = a + $urandom_range(1, 3);
        if (b > lim) b = lim;
        send_request(odfw_pkg::CMD_ADD, odfw_pkg::NODE_W'(a), odfw_pkg::NODE_W'(b));
      end else begin
        send_request(odfw_pkg::CMD_ADD, odfw_pkg::NODE_W'($urandom_range(1, lim)),
                     odfw_pkg::NODE_W'($urandom_range(1, lim)));
      end
    end
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin : check_results
    visit_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (visit_q.size() == 0) begin
          $error("unexpected result: visited_node %0d last %0b",
                 m_tdata[odfw_pkg::NODE_W-1:0], m_tlast);
          errors++;
        end else begin
          want = visit_q.pop_front();
          if (m_tdata[odfw_pkg::NODE_W-1:0] !== want.node) begin
            $error("visited_node: expected %0d, got %0d", want.node,
                   m_tdata[odfw_pkg::NODE_W-1:0]);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            errors++;
          end
        end
      end
      case (ready_mode)
        READY_ALWAYS: begin
          m_tready <= 1'b1;
        end
        READY_RANDOM: begin
          m_tready <= ($urandom_range(0, 2) != 0);
        end
        default: begin
          ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
          m_tready      <= ready_pattern[0];
        end
      endcase
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ordered_depth_first_walk_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (adj_rows[i]) adj_rows[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_node_count_limits();
    test_random_phase(7'd64, 30, READY_ALWAYS, 1'b0);
    test_random_phase(7'd12, 26, READY_RANDOM, 1'b1);
    test_random_phase(7'd127, 28, READY_PATTERN, 1'b1);
    test_random_phase(7'd5, 22, READY_RANDOM, 1'b0);
    test_random_phase(7'd40, 28, READY_PATTERN, 1'b1);
    test_random_phase(7'd0, 14, READY_ALWAYS, 1'b1);
    test_random_phase(7'd20, 26, READY_RANDOM, 1'b1);
    test_random_phase(7'd64, 28, READY_PATTERN, 1'b0);
    settle();
    if (errors == 0) begin
      $display("ordered_depth_first_walk_unit regression: pass");
    end else begin
      $display("ordered_depth_first_walk_unit regression: fail");
    end
    $finish;
  end

endmodule
